// ===== sv/dafc_pkg.sv =====
// ----------------------------------------------------------------------------
// dafc_pkg
// shared constants, state record, exponential tables and saturation helper
// ----------------------------------------------------------------------------
`default_nettype none

package dafc_pkg;

  localparam int CHANNELS   = 1024;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int EXP_CUTOFF = 12;
  localparam int DIV_W      = 42;   // |num| * 256 magnitude
  localparam int DEN_W      = 34;

  localparam logic signed [31:0] LOG_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic signed [31:0] lsc;
  } dafc_state_t;

  localparam int STATE_W = $bits(dafc_state_t);

  // exp(-i), Q1.24
  function automatic logic [24:0] exp_int_q24(input logic [3:0] i);
    logic [24:0] r;
    case (i)
      4'd0:    r = 25'd16777216;
      4'd1:    r = 25'd6171993;
      4'd2:    r = 25'd2270549;
      4'd3:    r = 25'd835288;
      4'd4:    r = 25'd307285;
      4'd5:    r = 25'd113044;
      4'd6:    r = 25'd41587;
      4'd7:    r = 25'd15299;
      4'd8:    r = 25'd5628;
      4'd9:    r = 25'd2070;
      4'd10:   r = 25'd762;
      4'd11:   r = 25'd280;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

  // exp(-2^-(j+1)), Q0.24
  function automatic logic [23:0] exp_frac_q24(input logic [3:0] j);
    logic [23:0] r;
    case (j)
      4'd0:    r = 24'd10175896;
      4'd1:    r = 24'd13066109;
      4'd2:    r = 24'd14805841;
      4'd3:    r = 24'd15760736;
      4'd4:    r = 24'd16261035;
      4'd5:    r = 24'd16517109;
      4'd6:    r = 24'd16646655;
      4'd7:    r = 24'd16711808;
      4'd8:    r = 24'd16744480;
      4'd9:    r = 24'd16760840;
      4'd10:   r = 24'd16769026;
      4'd11:   r = 24'd16773120;
      4'd12:   r = 24'd16775168;
      4'd13:   r = 24'd16776192;
      4'd14:   r = 24'd16776704;
      4'd15:   r = 24'd16776960;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -34'sh0_8000_0000) r = LOG_MIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dafc_state_ram.sv =====
// ----------------------------------------------------------------------------
// dafc_state_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dafc_state_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/dafc_exp_unit.sv =====
// ----------------------------------------------------------------------------
// dafc_exp_unit
// exp(-d) for d >= 0 in q19.16, result q1.16, one fraction bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dafc_exp_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [34:0] arg,
  output logic             done,
  output logic [16:0]      result
);

  typedef enum logic {X_IDLE, X_RUN} xstate_t;

  localparam logic [34:0] CUT = 35'(dafc_pkg::EXP_CUTOFF) << 16;

  xstate_t     state_r;
  logic [3:0]  cnt_r;
  logic [24:0] acc_r;
  logic [15:0] frac_r;
  logic        done_r;
  logic [48:0] prod;
  logic [25:0] rnd;

  assign prod   = 49'(acc_r) * 49'(dafc_pkg::exp_frac_q24(cnt_r)) + 49'(1 << 23);
  assign rnd    = 26'(acc_r) + 26'd128;
  assign result = rnd[24:8];
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= X_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        X_IDLE: begin
          if (start) begin
            cnt_r   <= '0;
            state_r <= X_RUN;
            if (arg >= CUT) begin
              acc_r  <= '0;
              frac_r <= '0;
            end else begin
              acc_r  <= dafc_pkg::exp_int_q24(arg[19:16]);
              frac_r <= arg[15:0];
            end
          end
        end
        X_RUN: begin
          // msb of the fraction pairs with exp(-1/2)
          if (frac_r[4'd15 - cnt_r]) begin
            acc_r <= prod[48:24];
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= X_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= X_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dafc_div_unit.sv =====
// ----------------------------------------------------------------------------
// dafc_div_unit
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dafc_div_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dafc_pkg::DIV_W-1:0]    dividend,
  input  wire logic [dafc_pkg::DEN_W-1:0]    divisor,
  output logic                               done,
  output logic [dafc_pkg::DIV_W-1:0]         quotient
);

  localparam int QW = dafc_pkg::DIV_W;
  localparam int DW = dafc_pkg::DEN_W;
  localparam int CW = $clog2(QW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   rs;
  logic          ge;

  assign rs       = {rem_r, quo_r[QW-1]};
  assign ge       = rs >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(rs - {1'b0, dvs_r}) : rs[DW-1:0];
        quo_r <= {quo_r[QW-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/decayed_attention_forward_core.sv =====
// ----------------------------------------------------------------------------
// decayed_attention_forward_core
// one decayed-attention time step per channel with per-channel stored state
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-entry state memory, one entry a cycle,
// and holds in_tready low meanwhile. For each step a small sequencer then runs
// four exponentials on one shared table-and-multiply unit (one fraction bit
// a cycle), six products on one shared 18x32 multiplier, and a bit-serial
// divider for the output. One step is in flight at a time; the result sits
// in an output register so the next step can start while it waits.
`default_nettype none

module decayed_attention_forward_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // channel[9:0], key_log[25:10], value_in[41:26], decay_log[57:42],
  // bonus_log[73:58], zero pad
  input  wire logic [79:0] in_tdata,
  // seq_start[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // weighted_out[15:0], out_channel[25:16], zero pad
  output logic [31:0]      out_tdata
);

  localparam int CW = dafc_pkg::CH_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_EA, S_EAW, S_EB, S_EBW,
    S_M0, S_M1, S_M2, S_SUM, S_DIVW, S_OUT
  } state_t;

  state_t state_r;
  logic [CW-1:0] clr_idx_r;
  logic [CW-1:0] c_r;
  logic [9:0]    ch_r;
  logic          seq_r;
  logic          ph_r;
  logic signed [23:0] k_r, w_r, u_r;
  logic signed [15:0] v_r;
  logic signed [31:0] o_r, p_r, q_r;
  logic signed [33:0] mx_r;
  logic [16:0]   a_r, b_r;
  logic signed [33:0] t1_r, t2_r, t3_r;
  logic          neg_r;
  logic signed [15:0] y_r;
  logic          out_valid_r;
  logic [15:0]   out_y_r;
  logic [9:0]    out_ch_r;

  // state memory
  dafc_pkg::dafc_state_t rd_st, wr_st;
  logic [dafc_pkg::STATE_W-1:0] rdata;
  logic          we;
  logic [CW-1:0] waddr;

  assign rd_st = dafc_pkg::dafc_state_t'(rdata);
  assign we    = (state_r == S_CLEAR) || (state_r == S_SUM && ph_r);
  assign waddr = (state_r == S_CLEAR) ? clr_idx_r : c_r;

  dafc_state_ram #(
    .DEPTH (dafc_pkg::CHANNELS),
    .WIDTH (dafc_pkg::STATE_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_st),
    .raddr (c_r),
    .rdata (rdata)
  );

  // state as loaded, a new sequence starts from the cleared record
  logic signed [31:0] o_ld, p_ld, q_ld;
  logic signed [33:0] ku, mx_ld, wo, k34, mx_ph1;
  assign o_ld  = seq_r ? dafc_pkg::LOG_MIN : rd_st.lsc;
  assign p_ld  = seq_r ? 32'sd0 : rd_st.num;
  assign q_ld  = seq_r ? 32'sd0 : rd_st.den;
  assign ku    = 34'(k_r) + 34'(u_r);
  assign mx_ld = (34'(o_ld) > ku) ? 34'(o_ld) : ku;
  assign wo    = 34'(o_r) + 34'(w_r);
  assign k34   = 34'(k_r);
  assign mx_ph1 = (wo > k34) ? wo : k34;

  // exponential unit
  logic signed [34:0] d_a, d_b;
  logic          exp_start, exp_done;
  logic [34:0]   exp_arg;
  logic [16:0]   exp_res;
  assign d_a       = 35'(mx_r) - 35'(ph_r ? wo : 34'(o_r));
  assign d_b       = 35'(mx_r) - 35'(ph_r ? k34 : ku);
  assign exp_start = (state_r == S_EA) || (state_r == S_EB);
  assign exp_arg   = (state_r == S_EA) ? d_a : d_b;

  dafc_exp_unit u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (exp_start),
    .arg    (exp_arg),
    .done   (exp_done),
    .result (exp_res)
  );

  // shared multiplier, products truncated toward zero
  logic [16:0]        fac;
  logic signed [31:0] mop;
  logic signed [49:0] prod;
  logic signed [33:0] tr16, tr8;
  assign fac  = (state_r == S_M2) ? b_r : a_r;
  assign mop  = (state_r == S_M0) ? p_r : (state_r == S_M1) ? q_r : 32'(v_r);
  assign prod = 50'(signed'({1'b0, fac})) * 50'(mop);
  assign tr16 = 34'((prod + (prod < 0 ? 50'sd65535 : 50'sd0)) >>> 16);
  assign tr8  = 34'((prod + (prod < 0 ? 50'sd255 : 50'sd0)) >>> 8);

  // output division
  logic signed [33:0] num, den, den_c, num_abs;
  logic          div_start, div_done;
  logic [dafc_pkg::DIV_W-1:0] quo;
  assign num     = t1_r + t3_r;
  assign den     = t2_r + 34'(signed'({1'b0, b_r}));
  assign den_c   = (den < 34'sd1) ? 34'sd1 : den;
  assign num_abs = (num < 0) ? -num : num;
  assign div_start = (state_r == S_SUM) && !ph_r;

  dafc_div_unit u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({num_abs[33:0], 8'd0}),
    .divisor  (den_c[33:0]),
    .done     (div_done),
    .quotient (quo)
  );

  logic signed [15:0] y_sat;
  always_comb begin
    if (!neg_r) begin
      y_sat = (quo > 42'd32767) ? 16'sh7FFF : quo[15:0];
    end else begin
      y_sat = (quo > 42'd32768) ? 16'sh8000 : 16'(-quo[15:0]);
    end
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_st.num = 32'sd0;
      wr_st.den = 32'sd0;
      wr_st.lsc = dafc_pkg::LOG_MIN;
    end else begin
      wr_st.num = dafc_pkg::sat32(num);
      wr_st.den = dafc_pkg::sat32(den);
      wr_st.lsc = dafc_pkg::sat32(mx_r);
    end
  end

  logic out_free;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_ch_r, out_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
    end else begin
      // the output register reloads in S_OUT instead
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + CW'(1);
          if (clr_idx_r == CW'(dafc_pkg::CHANNELS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            ch_r    <= in_tdata[9:0];
            c_r     <= CW'(in_tdata[9:0] % dafc_pkg::CHANNELS);
            k_r     <= {in_tdata[25:10], 8'd0};
            v_r     <= in_tdata[41:26];
            w_r     <= {in_tdata[57:42], 8'd0};
            u_r     <= {in_tdata[73:58], 8'd0};
            seq_r   <= in_tuser;
            ph_r    <= 1'b0;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_LOAD;
        S_LOAD: begin
          o_r     <= o_ld;
          p_r     <= p_ld;
          q_r     <= q_ld;
          mx_r    <= mx_ld;
          state_r <= S_EA;
        end
        S_EA: state_r <= S_EAW;
        S_EAW: begin
          if (exp_done) begin
            a_r     <= exp_res;
            state_r <= S_EB;
          end
        end
        S_EB: state_r <= S_EBW;
        S_EBW: begin
          if (exp_done) begin
            b_r     <= exp_res;
            state_r <= S_M0;
          end
        end
        S_M0: begin
          t1_r    <= tr16;
          state_r <= S_M1;
        end
        S_M1: begin
          t2_r    <= tr16;
          state_r <= S_M2;
        end
        S_M2: begin
          t3_r    <= tr8;
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (!ph_r) begin
            neg_r   <= num < 0;
            state_r <= S_DIVW;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            y_r     <= y_sat;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_y_r     <= y_r;
            out_ch_r    <= ch_r;
            ph_r        <= 1'b1;
            mx_r        <= mx_ph1;
            state_r     <= S_EA;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dafc_checker.sv =====
// ----------------------------------------------------------------------------
// dafc_checker
// port-level checks on the core, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

module dafc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // block is busy after taking a transfer and does not stay ready
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after a transfer");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid during reset clearing");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:26] == 6'd0)
    else $error("output pad bits not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed");

endmodule

bind decayed_attention_forward_core dafc_checker u_dafc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// random and directed time steps through the decayed-attention core, each
// output transfer checked against a per-channel fixed-point predictor
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              seq_start;
    logic signed [15:0] bonus_log;
    logic signed [15:0] decay_log;
    logic signed [15:0] value_in;
    logic signed [15:0] key_log;
    logic [9:0]         channel;
  } step_t;

  typedef struct packed {
    logic [9:0]         out_channel;
    logic signed [15:0] weighted_out;
  } wkv_out_t;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  decayed_attention_forward_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  longint num_st [dafc_pkg::CHANNELS];
  longint den_st [dafc_pkg::CHANNELS];
  longint lsc_st [dafc_pkg::CHANNELS];

  step_t    pending_steps[$];
  wkv_out_t expected_outs[$];
  int       errors = 0;
  bit       stim_done = 1'b0;

  localparam longint EXP_I [12] = '{16777216, 6171993, 2270549, 835288, 307285,
    113044, 41587, 15299, 5628, 2070, 762, 280};
  localparam longint EXP_F [16] = '{10175896, 13066109, 14805841, 15760736,
    16261035, 16517109, 16646655, 16711808, 16744480, 16760840, 16769026,
    16773120, 16775168, 16776192, 16776704, 16776960};

  function automatic longint neg_exp_q16(longint d);
    longint acc;
    if (d < 0) d = 0;
    if (d >= (longint'(12) << 16)) return 0;
    acc = EXP_I[d >> 16];
    for (int b = 1; b <= 16; b++)
      if ((d >> (16 - b)) & 1) acc = (acc * EXP_F[b - 1] + (1 << 23)) >> 24;
    return (acc + 128) >> 8;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic wkv_out_t predict_wkv(step_t s);
    int c;
    longint k, v, w, u, ku, o, p, q, mx, a, b, num, den, y, wo;
    wkv_out_t r;
    c = s.channel % dafc_pkg::CHANNELS;
    if (s.seq_start) begin
      num_st[c] = 0; den_st[c] = 0; lsc_st[c] = -(longint'(1) << 31);
    end
    k = longint'(s.key_log) * 256;
    v = longint'(s.value_in);
    w = longint'(s.decay_log) * 256;
    u = longint'(s.bonus_log) * 256;
    o = lsc_st[c]; p = num_st[c]; q = den_st[c];
    ku = k + u;
    mx = o > ku ? o : ku;
    a = neg_exp_q16(mx - o);
    b = neg_exp_q16(mx - ku);
    num = (a * p) / 65536 + (b * v) / 256;
    den = (a * q) / 65536 + b;
    if (den < 1) den = 1;
    y = clamp((num * 256) / den, -32768, 32767);
    wo = w + o;
    mx = wo > k ? wo : k;
    a = neg_exp_q16(mx - wo);
    b = neg_exp_q16(mx - k);
    num_st[c] = clamp((a * p) / 65536 + (b * v) / 256, -(longint'(1) << 31), 2147483647);
    den_st[c] = clamp((a * q) / 65536 + b, -(longint'(1) << 31), 2147483647);
    lsc_st[c] = clamp(mx, -(longint'(1) << 31), 2147483647);
    r.weighted_out = y[15:0];
    r.out_channel = s.channel;
    return r;
  endfunction

  function automatic step_t rand_step(logic [9:0] ch, bit start);
    step_t s;
    s.channel = ch;
    s.seq_start = start;
    // mostly moderate log values so the exponentials stay in range
    if ($urandom_range(0, 9) == 0) begin
      s.key_log = $urandom; s.value_in = $urandom;
      s.decay_log = $urandom; s.bonus_log = $urandom;
    end else begin
      s.key_log = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      s.value_in = $urandom;
      s.decay_log = -$signed(16'($urandom_range(0, 767)));
      s.bonus_log = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
    end
    return s;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_steps[0].seq_start;
          in_tdata <= {6'd0, pending_steps[0][73:0]};
          void'(pending_steps.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // predict at input transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_outs.push_back(predict_wkv(step_t'({in_tuser, in_tdata[73:0]})));
  end

  // receiver stall pattern, with one long hold-off
  int ready_cnt = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      ready_cnt <= ready_cnt + 1;
      if (ready_cnt >= 3000 && ready_cnt < 7000) begin
        out_tready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
      end else if ((ready_cnt / 2000) % 3 == 2) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0) ^ ((ready_cnt % 37) < 5);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    wkv_out_t got, exp_o;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[25:0];
      if (expected_outs.size() == 0) begin
        $display("%0t: unexpected output transfer %h", $realtime, got);
        errors = errors + 1;
      end else begin
        exp_o = expected_outs.pop_front();
        if (got.weighted_out !== exp_o.weighted_out) begin
          $display("%0t: weighted_out expected %0d actual %0d", $realtime,
                   exp_o.weighted_out, got.weighted_out);
          errors = errors + 1;
        end
        if (got.out_channel !== exp_o.out_channel) begin
          $display("%0t: out_channel expected %0d actual %0d", $realtime,
                   exp_o.out_channel, got.out_channel);
          errors = errors + 1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else if (!stim_done || expected_outs.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL decayed_attention_forward_core");
        $finish;
      end
    end
  end

  initial begin
    step_t s;
    logic [9:0] ch;
    for (int c = 0; c < dafc_pkg::CHANNELS; c++) begin
      num_st[c] = 0; den_st[c] = 0; lsc_st[c] = -(longint'(1) << 31);
    end
    // directed: field extremes, fresh channel, saturating log scale, high channel
    s = '{1'b1, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 10'd0};
    pending_steps.push_back(s);
    s = '{1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 10'd0};
    pending_steps.push_back(s);
    s = '{1'b0, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 10'd0};
    pending_steps.push_back(s);
    s = '{1'b0, 16'sh8000, 16'sh8000, 16'sh1234, 16'sh8000, 10'd0};
    pending_steps.push_back(s);
    s = '{1'b0, 16'sh0000, 16'shFF00, 16'sh0100, 16'sh0000, 10'd1023};
    pending_steps.push_back(s);
    s = '{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 10'd1023};
    pending_steps.push_back(s);
    s = '{1'b1, 16'shFFFF, 16'sh0000, 16'shFFFF, 16'shFFFF, 10'd1023};
    pending_steps.push_back(s);
    s = '{1'b0, 16'sh0C00, 16'shF400, 16'sh0080, 16'sh0000, 10'd512};
    pending_steps.push_back(s);
    s = '{1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'shF400, 10'd512};
    pending_steps.push_back(s);
    // random: sequences on a few channels, some starting fresh
    for (int i = 0; i < 800; i++) begin
      ch = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
      pending_steps.push_back(rand_step(ch, $urandom_range(0, 15) == 0));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_steps.size() == 0 && !in_tvalid);
    stim_done = 1'b1;
    wait (expected_outs.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_outs.size() == 0)
      $display("PASS decayed_attention_forward_core");
    else
      $display("FAIL decayed_attention_forward_core");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/dafc_pkg.sv
sv/dafc_state_ram.sv
sv/dafc_exp_unit.sv
sv/dafc_div_unit.sv
sv/decayed_attention_forward_core.sv
sv/dafc_checker.sv
tb/sv/testbench.sv
